// ===== rtl/binary_to_decimal_ascii_core_defines.svh =====
// assertion macros shared by the checker of the decimal ascii converter
// needs a clk and an rst signal in the scope where a macro is used
`ifndef BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_CORE_DEFINES_SVH

// clocked property, switched off while reset is high
`define BDAC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked property that also holds through reset
`define BDAC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/bdac_pkg.sv =====
// types and constants of the binary to decimal ascii converter
// used by bdac_cell, binary_to_decimal_ascii_core and bdac_checker
package bdac_pkg;

  localparam int VALUE_W   = 64;
  localparam int CAP_W     = 8;
  localparam int CHAR_W    = 8;
  localparam int COUNT_W   = 5;
  localparam int BCD_W     = 4;
  localparam int MAX_DIGITS = 20;
  // binary bits taken into the digit chain per cycle
  localparam int STEP_BITS = 4;
  localparam int PTR_W     = $clog2(MAX_DIGITS);

  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0]  ASCII_NINE = 8'h39;
  localparam logic [COUNT_W-1:0] MAX_COUNT  = COUNT_W'(MAX_DIGITS);

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [CAP_W-1:0]   capacity;
  } item_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  digit_char;
    logic               is_last;
    logic               overflow;
    logic [COUNT_W-1:0] digit_count;
  } result_t;

  // control fanned out to every digit cell
  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_COUNT = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

endpackage

// ===== rtl/bdac_cell.sv =====
// one decimal digit cell of the shift-and-add-3 chain
// depends on bdac_pkg; takes binary bits from the cell below, passes bits up
module bdac_cell (
  input  logic                             clk,
  input  bdac_pkg::cell_ctrl_t             ctrl,
  input  logic [bdac_pkg::STEP_BITS-1:0]   carry_in,
  output logic [bdac_pkg::STEP_BITS-1:0]   carry_out,
  output logic [bdac_pkg::BCD_W-1:0]       digit
);

  logic [bdac_pkg::BCD_W-1:0] digit_next;

  // several correct-then-shift steps, first bit in the top index
  always_comb begin : step_logic
    logic [bdac_pkg::BCD_W-1:0] d;
    logic [bdac_pkg::BCD_W-1:0] adj;
    d   = digit;
    adj = digit;
    for (int j = bdac_pkg::STEP_BITS - 1; j >= 0; j--) begin
      adj          = (d >= 4'd5) ? (d + 4'd3) : d;
      carry_out[j] = adj[bdac_pkg::BCD_W-1];
      d            = {adj[bdac_pkg::BCD_W-2:0], carry_in[j]};
    end
    digit_next = d;
  end

  // digit register
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      digit <= '0;
    end else if (ctrl.shift) begin
      digit <= digit_next;
    end
  end

endmodule

// ===== rtl/binary_to_decimal_ascii_core.sv =====
// Converts an unsigned value to decimal ascii, most significant digit first.
// One transaction is taken at a time: it is accepted in the idle state, then
// the value enters a chain of twenty digit cells four bits a cycle
// (shift-and-add-3), the digit count is found in a count state,
// then one result per cycle while the output side takes them (n digits, or a
// single overflow result). The output register lets the next item be taken
// while the last result still waits.
// depends on bdac_pkg and bdac_cell
module binary_to_decimal_ascii_core #(
  parameter int VALUE_BITS = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  bdac_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output bdac_pkg::result_t result
);

  localparam int STEPS    = (VALUE_BITS + bdac_pkg::STEP_BITS - 1) / bdac_pkg::STEP_BITS;
  localparam int PAD_BITS = STEPS * bdac_pkg::STEP_BITS;
  localparam int STEP_W   = $clog2(STEPS);

  bdac_pkg::state_t                state;
  bdac_pkg::state_t                state_next;
  logic [STEP_W-1:0]               step_cnt;
  logic [PAD_BITS-1:0]             value_sh;
  logic [bdac_pkg::CAP_W-1:0]      cap;
  logic [bdac_pkg::COUNT_W-1:0]    count;
  logic [bdac_pkg::COUNT_W-1:0]    count_calc;
  logic                            ovf;
  logic [bdac_pkg::PTR_W-1:0]      ptr;
  logic                            load;
  logic                            accept;
  bdac_pkg::result_t               result_next;
  bdac_pkg::cell_ctrl_t            cell_ctrl;

  logic [bdac_pkg::STEP_BITS-1:0]  carry [bdac_pkg::MAX_DIGITS];
  logic [bdac_pkg::BCD_W-1:0]      digits [bdac_pkg::MAX_DIGITS];

  assign accept     = item_valid && !item_stall;
  assign item_stall = (state != bdac_pkg::ST_IDLE);
  assign load       = (state == bdac_pkg::ST_EMIT) && (!result_valid || !result_stall);

  assign cell_ctrl.clear = accept;
  assign cell_ctrl.shift = (state == bdac_pkg::ST_CONV);

  // digit chain, cell 0 fed from the top of the value shifter
  assign carry[0] = value_sh[PAD_BITS-1 -: bdac_pkg::STEP_BITS];

  for (genvar i = 0; i < bdac_pkg::MAX_DIGITS; i++) begin : g_cell
    if (i < bdac_pkg::MAX_DIGITS - 1) begin : g_mid
      bdac_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .carry_in  (carry[i]),
        .carry_out (carry[i+1]),
        .digit     (digits[i])
      );
    end else begin : g_top
      bdac_cell u_cell (
        .clk       (clk),
        .ctrl      (cell_ctrl),
        .carry_in  (carry[i]),
        .carry_out (),
        .digit     (digits[i])
      );
    end
  end

  // highest nonzero digit gives the count, at least one digit
  always_comb begin
    count_calc = bdac_pkg::COUNT_W'(1);
    for (int i = 1; i < bdac_pkg::MAX_DIGITS; i++) begin
      if (digits[i] != '0) begin
        count_calc = bdac_pkg::COUNT_W'(i + 1);
      end
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      bdac_pkg::ST_IDLE: begin
        if (accept) state_next = bdac_pkg::ST_CONV;
      end
      bdac_pkg::ST_CONV: begin
        if (step_cnt == '0) state_next = bdac_pkg::ST_COUNT;
      end
      bdac_pkg::ST_COUNT: begin
        state_next = bdac_pkg::ST_EMIT;
      end
      bdac_pkg::ST_EMIT: begin
        if (load && (ovf || ptr == '0)) state_next = bdac_pkg::ST_IDLE;
      end
      default: begin
        state_next = bdac_pkg::ST_IDLE;
      end
    endcase
  end

  // result word for the next output transaction
  always_comb begin
    result_next.digit_count = count;
    result_next.overflow    = ovf;
    if (ovf) begin
      result_next.digit_char = '0;
      result_next.is_last    = 1'b1;
    end else begin
      result_next.digit_char = bdac_pkg::ASCII_ZERO | bdac_pkg::CHAR_W'(digits[ptr]);
      result_next.is_last    = (ptr == '0);
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= bdac_pkg::ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      value_sh <= PAD_BITS'(item.value[VALUE_BITS-1:0]);
      cap      <= item.capacity;
      step_cnt <= STEP_W'(STEPS - 1);
    end else if (state == bdac_pkg::ST_CONV) begin
      value_sh <= {value_sh[PAD_BITS-bdac_pkg::STEP_BITS-1:0], bdac_pkg::STEP_BITS'(0)};
      step_cnt <= step_cnt - STEP_W'(1);
    end
    if (state == bdac_pkg::ST_COUNT) begin
      count <= count_calc;
      ovf   <= ({{(bdac_pkg::CAP_W - bdac_pkg::COUNT_W){1'b0}}, count_calc} > cap);
      ptr   <= bdac_pkg::PTR_W'(count_calc - bdac_pkg::COUNT_W'(1));
    end else if (load) begin
      ptr <= ptr - bdac_pkg::PTR_W'(1);
    end
    if (load) begin
      result <= result_next;
    end
  end

endmodule

// ===== rtl/bdac_checker.sv =====
// port checker for binary_to_decimal_ascii_core, bound to the top level
// depends on bdac_pkg and binary_to_decimal_ascii_core_defines.svh
`include "binary_to_decimal_ascii_core_defines.svh"

module bdac_checker (
  input logic              clk,
  input logic              rst,
  input logic              item_valid,
  input logic              item_stall,
  input logic              result_valid,
  input logic              result_stall,
  input bdac_pkg::result_t result
);

  logic item_taken;
  logic res_held;
  logic res_taken;
  logic ovf_shape_ok;
  logic digit_ok;

  // handshake terms
  assign item_taken = item_valid && !item_stall;
  assign res_held   = result_valid && result_stall;
  assign res_taken  = result_valid && !result_stall;

  // shape of an overflow result and of a digit result
  assign ovf_shape_ok = result.is_last && (result.digit_char == '0) &&
                        (result.digit_count != '0);
  assign digit_ok     = (result.digit_char >= bdac_pkg::ASCII_ZERO) &&
                        (result.digit_char <= bdac_pkg::ASCII_NINE) &&
                        (result.digit_count <= bdac_pkg::MAX_COUNT);

  // a stalled result holds
  `BDAC_ASSERT(a_result_hold, res_held |=> result_valid && $stable(result), "stalled result changed")

  // one transaction in work at a time
  `BDAC_ASSERT(a_one_item, item_taken |=> item_stall, "second item taken while converting")

  // overflow result is alone and carries no character
  `BDAC_ASSERT(a_ovf_shape, result_valid && result.overflow |-> ovf_shape_ok, "bad overflow result")

  // digits are ascii decimal and digits of one item follow without gaps
  `BDAC_ASSERT(a_digit_range, result_valid && !result.overflow |-> digit_ok, "digit out of range")

  `BDAC_ASSERT(a_no_gap, res_taken && !result.is_last |=> result_valid, "gap inside a digit string")

endmodule

bind binary_to_decimal_ascii_core bdac_checker u_bdac_checker (.*);
